>>> src/sbl_pkg.sv
// Shared constants, types and helpers for the scaled masked blitter.
// No dependencies; sbl_div and the core refer to it by scoped names.
`default_nettype none
package sbl_pkg;

    localparam int IMAGE_WIDTH  = 256;
    localparam int IMAGE_HEIGHT = 256;
    localparam int STORE_DEPTH  = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int OPAQUE_LIMIT = 384;
    localparam int PADDR_W      = 6;
    localparam int DIV_STAGES   = 8;
    localparam int DIV_STEPS    = 16 / DIV_STAGES;

    localparam logic [1:0] CMD_LOAD_SRC  = 2'd0;
    localparam logic [1:0] CMD_LOAD_MASK = 2'd1;
    localparam logic [1:0] CMD_DRAW      = 2'd2;
    localparam logic [1:0] CMD_UNUSED    = 2'd3;

    localparam logic [1:0] ST_WRITE   = 2'd0;
    localparam logic [1:0] ST_SKIP    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [2:0] REG_DEST_WIN = 3'd0;
    localparam logic [2:0] REG_SRC_WIN  = 3'd1;
    localparam logic [2:0] REG_MASK_WIN = 3'd2;
    localparam logic [2:0] REG_DEST_BND = 3'd3;
    localparam logic [2:0] REG_SRC_BND  = 3'd4;
    localparam logic [2:0] REG_MASK_BND = 3'd5;
    localparam logic [2:0] REG_MASK_ON  = 3'd6;

    typedef struct packed {
        logic [1:0]        cmd;
        logic              err;
        logic              inwin;
        logic [15:0]       px;
        logic [15:0]       py;
        logic [31:0]       pix;
        logic              opq;
        logic              lok;
        logic [ADDR_W-1:0] laddr;
    } t_side;

    function automatic logic [ADDR_W-1:0] store_addr(input logic [15:0] x,
                                                     input logic [15:0] y);
        logic [31:0] a;
        a = 32'(y) * 32'(IMAGE_WIDTH) + 32'(x);
        return a[ADDR_W-1:0];
    endfunction

    // one restoring step on {remainder, numerator bits / quotient bits}
    function automatic logic [31:0] div_step(input logic [31:0] acc,
                                             input logic [15:0] den);
        logic [16:0] t;
        logic [16:0] d;
        logic [15:0] rem;
        logic        q;
        t = acc[31:15];
        d = {1'b0, den};
        if (t >= d) begin
            t   = t - d;
            q   = 1'b1;
        end else begin
            q   = 1'b0;
        end
        rem = t[15:0];
        return {rem, acc[14:0], q};
    endfunction

endpackage
`default_nettype wire

>>> src/sbl_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
`default_nettype none
module sbl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> src/sbl_div.sv
// Pipelined restoring divider, 32-bit numerator by 16-bit divisor, 16-bit quotient.
// Depends on sbl_pkg; quotient must fit 16 bits (numerator[31:16] < divisor).
`default_nettype none
module sbl_div (
    input  wire logic                              i_clk,
    input  wire logic [sbl_pkg::DIV_STAGES-1:0]    i_en,
    input  wire logic [31:0]                       i_num,
    input  wire logic [15:0]                       i_den,
    output logic      [15:0]                       o_quo
);

    logic [31:0] r_acc [sbl_pkg::DIV_STAGES];
    logic [31:0] n_acc [sbl_pkg::DIV_STAGES];

    for (genvar k = 0; k < sbl_pkg::DIV_STAGES; k++) begin : g_stage
        always_comb begin
            logic [31:0] a;
            a = (k == 0) ? i_num : r_acc[(k == 0) ? 0 : k - 1];
            for (int s = 0; s < sbl_pkg::DIV_STEPS; s++) begin
                a = sbl_pkg::div_step(a, i_den);
            end
            n_acc[k] = a;
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_acc[k] <= n_acc[k];
            end
        end
    end

    assign o_quo = r_acc[sbl_pkg::DIV_STAGES-1][15:0];

endmodule
`default_nettype wire

>>> src/scaled_masked_blit_core.sv
// Top level of the scaled masked blitter: config registers, clip, scale, stores.
// Depends on sbl_pkg, sbl_div and sbl_ram.
//
//  channel   direction  handshake                  contents
//  s_axis    in         tvalid/tready              tuser cmd, tdata load/draw request
//  m_axis    out        tvalid/tready              tuser status, tdata pixel write
//  apb       in         psel/penable/pwrite/pready 64-bit config registers at 8*i
//
// 13 register stages, one request per clock while the output is not stalled; the
// depth is set by the 8-stage divider, 2 quotient bits each.
// Synchronous active-low reset clears control and config; stores are unset.
// Each stage holds independently, so bubbles close up behind a stalled output.
`default_nettype none
module scaled_masked_blit_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [1:0]                  s_axis_tuser,  // cmd
    input  wire logic [63:0]                 s_axis_tdata,  // pos_x, pos_y, r, g, b, a
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [1:0]                  m_axis_tuser,  // status
    output logic      [63:0]                 m_axis_tdata,  // dest_x, dest_y, r, g, b, a
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sbl_pkg::PADDR_W-1:0] paddr,
    input  wire logic [63:0]                 pwdata,
    output logic      [63:0]                 prdata,
    output logic                             pready
);

    localparam int AW = sbl_pkg::ADDR_W;

    logic [63:0] r_dest_win, r_src_win, r_mask_win;
    logic [31:0] r_dest_bnd, r_src_bnd, r_mask_bnd;
    logic        r_mask_on;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_win <= '0;
            r_src_win  <= '0;
            r_mask_win <= '0;
            r_dest_bnd <= '0;
            r_src_bnd  <= '0;
            r_mask_bnd <= '0;
            r_mask_on  <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[5:3])
                sbl_pkg::REG_DEST_WIN: r_dest_win <= pwdata;
                sbl_pkg::REG_SRC_WIN:  r_src_win  <= pwdata;
                sbl_pkg::REG_MASK_WIN: r_mask_win <= pwdata;
                sbl_pkg::REG_DEST_BND: r_dest_bnd <= pwdata[31:0];
                sbl_pkg::REG_SRC_BND:  r_src_bnd  <= pwdata[31:0];
                sbl_pkg::REG_MASK_BND: r_mask_bnd <= pwdata[31:0];
                sbl_pkg::REG_MASK_ON:  r_mask_on  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            sbl_pkg::REG_DEST_WIN: prdata = r_dest_win;
            sbl_pkg::REG_SRC_WIN:  prdata = r_src_win;
            sbl_pkg::REG_MASK_WIN: prdata = r_mask_win;
            sbl_pkg::REG_DEST_BND: prdata = {32'd0, r_dest_bnd};
            sbl_pkg::REG_SRC_BND:  prdata = {32'd0, r_src_bnd};
            sbl_pkg::REG_MASK_BND: prdata = {32'd0, r_mask_bnd};
            sbl_pkg::REG_MASK_ON:  prdata = {63'd0, r_mask_on};
            default:               prdata = '0;
        endcase
    end

    // stage enables, ripple from the output back
    logic [13:1] r_v;
    logic [13:1] en;

    always_comb begin
        en[13] = !r_v[13] || m_axis_tready;
        for (int i = 12; i >= 1; i--) begin
            en[i] = !r_v[i] || en[i+1];
        end
    end

    assign s_axis_tready = en[1];

    // stage 1: input register
    logic [1:0]  r1_cmd;
    logic [63:0] r1_data;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_cmd  <= s_axis_tuser;
            r1_data <= s_axis_tdata;
        end
    end

    // stage 2: config check, clip, offsets, load prep
    sbl_pkg::t_side n_side2;
    sbl_pkg::t_side r_side [2:11];
    logic [15:0]    n2_dx, n2_dy, r2_dx, r2_dy;

    always_comb begin
        logic [15:0]        px, py;
        logic signed [17:0] dxs, dys, pxs, pys, rgt, bot;
        logic               err_m;
        logic [9:0]         sum;
        px  = r1_data[15:0];
        py  = r1_data[31:16];
        dxs = $signed({{2{r_dest_win[15]}}, r_dest_win[15:0]});
        dys = $signed({{2{r_dest_win[31]}}, r_dest_win[31:16]});
        pxs = $signed({2'b00, px});
        pys = $signed({2'b00, py});
        rgt = dxs + $signed({2'b00, r_dest_win[47:32]});
        bot = dys + $signed({2'b00, r_dest_win[63:48]});
        err_m = r_mask_on && (r_mask_win[47:32] == 16'd0 || r_mask_win[63:48] == 16'd0 ||
                              r_mask_bnd[15:0] == 16'd0 || r_mask_bnd[31:16] == 16'd0);
        sum = 10'(r1_data[39:32]) + 10'(r1_data[47:40]) + 10'(r1_data[55:48]);

        n_side2.cmd   = r1_cmd;
        n_side2.err   = r_dest_win[47:32] == 16'd0 || r_dest_win[63:48] == 16'd0 ||
                        r_src_win[47:32] == 16'd0 || r_src_win[63:48] == 16'd0 ||
                        r_dest_bnd[15:0] == 16'd0 || r_dest_bnd[31:16] == 16'd0 ||
                        r_src_bnd[15:0] == 16'd0 || r_src_bnd[31:16] == 16'd0 || err_m;
        n_side2.inwin = pxs >= dxs && pxs < rgt && px < r_dest_bnd[15:0] &&
                        pys >= dys && pys < bot && py < r_dest_bnd[31:16];
        n_side2.px    = px;
        n_side2.py    = py;
        n_side2.pix   = r1_data[63:32];
        n_side2.opq   = sum < 10'(sbl_pkg::OPAQUE_LIMIT);
        n_side2.lok   = 32'(px) < 32'(sbl_pkg::IMAGE_WIDTH) &&
                        32'(py) < 32'(sbl_pkg::IMAGE_HEIGHT);
        n_side2.laddr = sbl_pkg::store_addr(px, py);
        n2_dx = px - r_dest_win[15:0];
        n2_dy = py - r_dest_win[31:16];
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_dx     <= n2_dx;
            r2_dy     <= n2_dy;
        end
    end

    // stage 3: products
    logic [31:0] r3_psx, r3_psy, r3_pmx, r3_pmy;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_psx    <= {16'd0, r2_dx} * {16'd0, r_src_win[47:32]};
            r3_psy    <= {16'd0, r2_dy} * {16'd0, r_src_win[63:48]};
            r3_pmx    <= {16'd0, r2_dx} * {16'd0, r_mask_win[47:32]};
            r3_pmy    <= {16'd0, r2_dy} * {16'd0, r_mask_win[63:48]};
        end
    end

    // stages 4..11: dividers with sideband
    logic [15:0] q_sx, q_sy, q_mx, q_my;

    sbl_div u_div_sx (.i_clk(i_clk), .i_en(en[11:4]), .i_num(r3_psx),
                      .i_den(r_dest_win[47:32]), .o_quo(q_sx));
    sbl_div u_div_sy (.i_clk(i_clk), .i_en(en[11:4]), .i_num(r3_psy),
                      .i_den(r_dest_win[63:48]), .o_quo(q_sy));
    sbl_div u_div_mx (.i_clk(i_clk), .i_en(en[11:4]), .i_num(r3_pmx),
                      .i_den(r_dest_win[47:32]), .o_quo(q_mx));
    sbl_div u_div_my (.i_clk(i_clk), .i_en(en[11:4]), .i_num(r3_pmy),
                      .i_den(r_dest_win[63:48]), .o_quo(q_my));

    // sideband for stages 2..11
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_side[2] <= n_side2;
        end
        for (int i = 3; i <= 11; i++) begin
            if (en[i]) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // stage 12: range checks and store addresses
    logic [1:0]    r12_cmd;
    logic          r12_err, r12_pass, r12_lok, r12_opq;
    logic [15:0]   r12_px, r12_py;
    logic [31:0]   r12_pix;
    logic [AW-1:0] r12_saddr, r12_maddr;
    logic          n12_pass;
    logic [AW-1:0] n12_saddr, n12_maddr;

    always_comb begin
        logic signed [17:0] sx, sy, mx, my;
        logic [15:0]        sbw, sbh, mbw, mbh;
        logic               sok, mok;
        sx = $signed({{2{r_src_win[15]}}, r_src_win[15:0]}) + $signed({2'b00, q_sx});
        sy = $signed({{2{r_src_win[31]}}, r_src_win[31:16]}) + $signed({2'b00, q_sy});
        mx = $signed({{2{r_mask_win[15]}}, r_mask_win[15:0]}) + $signed({2'b00, q_mx});
        my = $signed({{2{r_mask_win[31]}}, r_mask_win[31:16]}) + $signed({2'b00, q_my});
        sbw = (32'(r_src_bnd[15:0]) > 32'(sbl_pkg::IMAGE_WIDTH)) ?
              16'(sbl_pkg::IMAGE_WIDTH) : r_src_bnd[15:0];
        sbh = (32'(r_src_bnd[31:16]) > 32'(sbl_pkg::IMAGE_HEIGHT)) ?
              16'(sbl_pkg::IMAGE_HEIGHT) : r_src_bnd[31:16];
        mbw = (32'(r_mask_bnd[15:0]) > 32'(sbl_pkg::IMAGE_WIDTH)) ?
              16'(sbl_pkg::IMAGE_WIDTH) : r_mask_bnd[15:0];
        mbh = (32'(r_mask_bnd[31:16]) > 32'(sbl_pkg::IMAGE_HEIGHT)) ?
              16'(sbl_pkg::IMAGE_HEIGHT) : r_mask_bnd[31:16];
        sok = sx >= 18'sd0 && sx < $signed({2'b00, sbw}) &&
              sy >= 18'sd0 && sy < $signed({2'b00, sbh});
        mok = !r_mask_on ||
              (mx >= 18'sd0 && mx < $signed({2'b00, mbw}) &&
               my >= 18'sd0 && my < $signed({2'b00, mbh}));
        n12_pass = r_side[11].inwin && sok && mok;
        if (r_side[11].cmd == sbl_pkg::CMD_DRAW) begin
            n12_saddr = sbl_pkg::store_addr(sx[15:0], sy[15:0]);
            n12_maddr = sbl_pkg::store_addr(mx[15:0], my[15:0]);
        end else begin
            n12_saddr = r_side[11].laddr;
            n12_maddr = r_side[11].laddr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[12]) begin
            r12_cmd   <= r_side[11].cmd;
            r12_err   <= r_side[11].err;
            r12_pass  <= n12_pass;
            r12_lok   <= r_side[11].lok;
            r12_opq   <= r_side[11].opq;
            r12_px    <= r_side[11].px;
            r12_py    <= r_side[11].py;
            r12_pix   <= r_side[11].pix;
            r12_saddr <= n12_saddr;
            r12_maddr <= n12_maddr;
        end
    end

    // stage 13: store access, result held here
    logic        src_we, mask_we, rd_en;
    logic [31:0] src_q;
    logic [0:0]  mask_q;

    assign src_we  = en[13] && r_v[12] && r12_lok && r12_cmd == sbl_pkg::CMD_LOAD_SRC;
    assign mask_we = en[13] && r_v[12] && r12_lok && r12_cmd == sbl_pkg::CMD_LOAD_MASK;
    assign rd_en   = en[13] && r_v[12] && r12_cmd == sbl_pkg::CMD_DRAW;

    sbl_ram #(.WIDTH(32), .DEPTH(sbl_pkg::STORE_DEPTH)) u_src_ram (
        .i_clk(i_clk), .i_we(src_we), .i_waddr(r12_saddr), .i_wdata(r12_pix),
        .i_re(rd_en), .i_raddr(r12_saddr), .o_rdata(src_q)
    );

    sbl_ram #(.WIDTH(1), .DEPTH(sbl_pkg::STORE_DEPTH)) u_mask_ram (
        .i_clk(i_clk), .i_we(mask_we), .i_waddr(r12_maddr), .i_wdata(r12_opq),
        .i_re(rd_en), .i_raddr(r12_maddr), .o_rdata(mask_q)
    );

    logic        r13_err, r13_pass;
    logic [15:0] r13_px, r13_py;

    always_ff @(posedge i_clk) begin
        if (en[13]) begin
            r13_err  <= r12_err;
            r13_pass <= r12_pass;
            r13_px   <= r12_px;
            r13_py   <= r12_py;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= s_axis_tvalid && s_axis_tuser != sbl_pkg::CMD_UNUSED;
            end
            for (int i = 2; i <= 12; i++) begin
                if (en[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
            if (en[13]) begin
                r_v[13] <= r_v[12] && r12_cmd == sbl_pkg::CMD_DRAW;
            end
        end
    end

    // result
    logic wr_ok;

    assign wr_ok = !r13_err && r13_pass && (!r_mask_on || mask_q[0]);

    always_comb begin
        m_axis_tvalid = r_v[13];
        if (r13_err) begin
            m_axis_tuser = sbl_pkg::ST_INVALID;
        end else if (wr_ok) begin
            m_axis_tuser = sbl_pkg::ST_WRITE;
        end else begin
            m_axis_tuser = sbl_pkg::ST_SKIP;
        end
        m_axis_tdata = wr_ok ? {src_q, r13_py, r13_px} : 64'd0;
    end

endmodule
`default_nettype wire
